### sv/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants for the waterfall colorizer
// Widths, register indexes, the queue word and the colour ramp.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int MAX_COLS  = 4096;
  localparam int ROWS      = 512;
  localparam int MAX_BINS  = 65536;

  localparam int LVL_W  = 16;
  localparam int BINS_W = 17;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CFG_W  = 17;
  localparam int IDX_W  = 2;
  localparam int QDEPTH = 2;

  localparam logic [IDX_W-1:0] REG_IN_BINS = 2'd0;
  localparam logic [IDX_W-1:0] REG_DB_MIN  = 2'd1;
  localparam logic [IDX_W-1:0] REG_DB_MAX  = 2'd2;

  // Configuration write as seen by the front and back parts.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  // One column word passed from the front to the back.
  typedef struct packed {
    logic signed [LVL_W-1:0] level;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    last;
    logic                    full;
  } pix_t;

  // Colour ramp stops in hundredths, packed {blue, green, red}.
  function automatic logic [23:0] ramp_stop(input logic [2:0] idx);
    logic [23:0] s;
    case (idx)
      3'd0:    s = {8'd0,   8'd0,   8'd0};
      3'd1:    s = {8'd55,  8'd0,   8'd0};
      3'd2:    s = {8'd90,  8'd55,  8'd0};
      3'd3:    s = {8'd20,  8'd85,  8'd0};
      3'd4:    s = {8'd0,   8'd90,  8'd95};
      3'd5:    s = {8'd0,   8'd20,  8'd95};
      3'd6:    s = {8'd100, 8'd100, 8'd100};
      default: s = 24'd0;
    endcase
    return s;
  endfunction

endpackage

### sv/spectrum_waterfall_colorizer_top.sv
// ----------------------------------------------------------------------------
// spectrum_waterfall_colorizer_top: FFT row to colour pixel converter
// Pools bins into columns, normalises and colour-maps each column.
// ----------------------------------------------------------------------------
// Each input word is one bin level; a pixel word leaves for each finished
// column. The front takes a bin every cycle while its two-word queue has
// room. The back handles one pixel at a time: the bit-serial normalising
// divide (skipped when the level clamps), then mapping, two multiply steps
// and the output register; it pops the next word only once idle. Rows are
// paced by the back, pooled rows also by the bins. No clearing pass.
module spectrum_waterfall_colorizer_top import swc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // bin_level
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata,   // red, green, blue, column, row
  output logic             m_tlast,   // row_done
  output logic             m_tuser    // history_full
);

  cfg_wr_t cfg;
  logic    push;
  pix_t    push_word;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  pix_t    q_word;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  swc_front u_front (
    .clk, .rst, .cfg,
    .in_valid (s_tvalid),
    .in_level (s_tdata),
    .in_ready (s_tready),
    .push, .push_word, .q_full
  );

  swc_queue u_queue (
    .clk, .rst, .push, .push_word,
    .full (q_full), .pop, .empty (q_empty), .pop_word (q_word)
  );

  swc_back u_back (
    .clk, .rst, .cfg, .q_empty, .q_word, .pop,
    .out_valid (m_tvalid), .out_ready (m_tready), .out_data (m_tdata),
    .out_last (m_tlast), .out_full (m_tuser)
  );

endmodule

### sv/swc_front.sv
// ----------------------------------------------------------------------------
// swc_front: bin intake and column pooling
// Tracks column boundaries, max-pools bins and tags each column word with
// its column, ring row and history flag.
// ----------------------------------------------------------------------------
module swc_front import swc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_wr_t                 cfg,
  input  logic                    in_valid,
  input  logic signed [LVL_W-1:0] in_level,
  output logic                    in_ready,
  output logic                    push,
  output pix_t                    push_word,
  input  logic                    q_full
);

  localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

  logic [BINS_W-1:0]       n_bins;
  logic [BINS_W-1:0]       bin_index;
  logic [COL_W-1:0]        column_index;
  logic [BINS_W-1:0]       next_boundary;
  logic [COL_W-1:0]        boundary_remainder;
  logic signed [LVL_W-1:0] pool_max;
  logic [ROW_W-1:0]        row_pointer;
  logic                    ring_full;

  logic [BINS_W-1:0] new_bins;
  logic              pooled;
  logic              new_pooled;
  logic [BINS_W-1:0] cur_width;
  logic [BINS_W-1:0] new_width;
  logic signed [LVL_W-1:0] pm;
  logic [BINS_W-1:0] bi_inc;
  logic [COL_W:0]    rem_sum;
  logic [ROW_W-1:0]  target;
  logic              emit;
  logic              last;

  // Clamp a written bin count to the supported range.
  function automatic logic [BINS_W-1:0] eff_bins(input logic [CFG_W-1:0] v);
    logic [BINS_W-1:0] r;
    r = v[BINS_W-1:0];
    if (r == '0) r = BINS_W'(1);
    if (r > BINS_W'(MAX_BINS)) r = BINS_W'(MAX_BINS);
    return r;
  endfunction

  assign new_bins   = eff_bins(cfg.data);
  assign pooled     = (n_bins > BINS_W'(MAX_COLS));
  assign new_pooled = (new_bins > BINS_W'(MAX_COLS));
  assign cur_width  = pooled ? BINS_W'(MAX_COLS) : n_bins;
  assign new_width  = new_pooled ? BINS_W'(MAX_COLS) : new_bins;
  assign in_ready   = !q_full;
  assign pm         = (in_level > pool_max) ? in_level : pool_max;
  assign bi_inc     = bin_index + BINS_W'(1);
  assign rem_sum    = {1'b0, boundary_remainder} + {1'b0, n_bins[COL_W-1:0]};
  assign target     = (row_pointer == '0) ? ROW_W'(ROWS - 1) : row_pointer - ROW_W'(1);

  // Pooled, a column is complete when the bin count reaches its boundary; unpooled, every bin is a column.
  always_comb begin
    emit = 1'b0;
    last = 1'b0;
    if (pooled) begin
      emit = (bi_inc >= next_boundary);
      last = (column_index == COL_W'(MAX_COLS - 1));
    end else begin
      emit = 1'b1;
      last = (bi_inc >= n_bins);
    end
  end

  assign push            = in_valid && in_ready && emit;
  assign push_word.level = pooled ? pm : in_level;
  assign push_word.col   = pooled ? column_index : bin_index[COL_W-1:0];
  assign push_word.row   = target;
  assign push_word.last  = last;
  assign push_word.full  = ring_full || (target == '0);

  // Row and boundary state.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_bins             <= BINS_W'(1024);
      bin_index          <= '0;
      column_index       <= '0;
      next_boundary      <= BINS_W'(1);
      boundary_remainder <= '0;
      pool_max           <= LVL_MIN;
      row_pointer        <= '0;
      ring_full          <= 1'b0;
    end else if (cfg.we && cfg.index == REG_IN_BINS) begin
      n_bins       <= new_bins;
      bin_index    <= '0;
      column_index <= '0;
      pool_max     <= LVL_MIN;
      if (new_pooled) begin
        next_boundary      <= new_bins >> COL_W;
        boundary_remainder <= new_bins[COL_W-1:0];
      end else begin
        next_boundary      <= BINS_W'(1);
        boundary_remainder <= '0;
      end
      // The ring restarts only when the row width changes.
      if (new_width != cur_width) begin
        row_pointer <= '0;
        ring_full   <= 1'b0;
      end
    end else if (in_valid && in_ready) begin
      if (emit && last) begin
        bin_index    <= '0;
        column_index <= '0;
        pool_max     <= LVL_MIN;
        if (pooled) begin
          next_boundary      <= n_bins >> COL_W;
          boundary_remainder <= n_bins[COL_W-1:0];
        end else begin
          next_boundary      <= BINS_W'(1);
          boundary_remainder <= '0;
        end
        row_pointer <= target;
        if (target == '0) ring_full <= 1'b1;
      end else if (pooled) begin
        bin_index <= bi_inc;
        if (emit) begin
          column_index       <= column_index + COL_W'(1);
          pool_max           <= LVL_MIN;
          next_boundary      <= next_boundary + (n_bins >> COL_W)
                                + BINS_W'(rem_sum[COL_W]);
          boundary_remainder <= rem_sum[COL_W-1:0];
        end else begin
          pool_max <= pm;
        end
      end else begin
        bin_index <= bi_inc;
      end
    end
  end

endmodule

### sv/swc_queue.sv
// ----------------------------------------------------------------------------
// swc_queue: short column word queue
// Decouples the pooling front from the colour mapping back.
// ----------------------------------------------------------------------------
module swc_queue import swc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pix_t push_word,
  output logic full,
  input  logic pop,
  output logic empty,
  output pix_t pop_word
);

  localparam int PW = $clog2(QDEPTH);

  pix_t           mem [QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full     = (count == (PW+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule

### sv/swc_back.sv
// ----------------------------------------------------------------------------
// swc_back: level normalisation and colour mapping
// Divides the level into a Q16 fraction bit by bit, then walks the ramp
// through a short multiply sequence into the output register.
// ----------------------------------------------------------------------------
module swc_back import swc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_wr_t     cfg,
  input  logic        q_empty,
  input  pix_t        q_word,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_data,
  output logic        out_last,
  output logic        out_full
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MAP  = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic [16:0] T_ONE  = 17'h10000;
  localparam logic [31:0] HALF   = 32'd3276800;
  localparam logic [12:0] RECIP  = 13'd5243;

  logic [2:0]              state;
  logic signed [LVL_W-1:0] db_min;
  logic signed [LVL_W-1:0] db_max;
  pix_t                    cur;
  logic [16:0]             rem;
  logic [15:0]             span;
  logic [15:0]             quot;
  logic [3:0]              cnt;
  logic [16:0]             t;
  logic [2:0]              seg;
  logic [16:0]             frac;
  logic [22:0]             num [3];
  logic [15:0]             yv  [3];

  logic signed [16:0] diff;
  logic signed [16:0] dspan;
  logic [15:0]        span_c;
  logic [16:0]        r2;
  logic [19:0]        x6;
  logic [2:0]         seg_c;
  logic [23:0]        lo_s;
  logic [23:0]        hi_s;
  logic [7:0]         qv [3];

  assign diff   = {q_word.level[LVL_W-1], q_word.level} - {db_min[LVL_W-1], db_min};
  assign dspan  = {db_max[LVL_W-1], db_max} - {db_min[LVL_W-1], db_min};
  assign span_c = (db_max > db_min) ? dspan[15:0] : 16'd128;
  assign r2     = {rem[15:0], 1'b0};
  assign x6     = {3'd0, t} * 20'd6;
  assign seg_c  = (x6[19:16] > 4'd5) ? 3'd5 : x6[18:16];
  assign lo_s   = ramp_stop(seg);
  assign hi_s   = ramp_stop(seg + 3'd1);
  assign pop    = (state == ST_IDLE) && !q_empty;

  // Final divide by one hundred through a reciprocal, capped at full scale.
  always_comb begin
    logic [28:0] p;
    for (int c = 0; c < 3; c++) begin
      p = {13'd0, yv[c]} * {16'd0, RECIP};
      qv[c] = (p[28:19] > 10'd255) ? 8'd255 : p[26:19];
    end
  end

  // Scale registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      db_min <= -16'sd12800;
      db_max <= 16'sd0;
    end else if (cfg.we && cfg.index == REG_DB_MIN) begin
      db_min <= cfg.data[LVL_W-1:0];
    end else if (cfg.we && cfg.index == REG_DB_MAX) begin
      db_max <= cfg.data[LVL_W-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output step reloads the register itself when the word leaves.
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur  <= q_word;
            span <= span_c;
            rem  <= {1'b0, diff[15:0]};
            quot <= '0;
            cnt  <= '0;
            if (diff <= 17'sd0) begin
              t     <= '0;
              state <= ST_MAP;
            end else if (diff[15:0] >= span_c) begin
              t     <= T_ONE;
              state <= ST_MAP;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (r2 >= {1'b0, span}) begin
            rem  <= r2 - {1'b0, span};
            quot <= {quot[14:0], 1'b1};
          end else begin
            rem  <= r2;
            quot <= {quot[14:0], 1'b0};
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            t     <= {1'b0, quot[14:0], (r2 >= {1'b0, span})};
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          seg   <= seg_c;
          frac  <= 17'(x6 - {seg_c, 16'd0});
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          for (int c = 0; c < 3; c++) begin
            logic signed [31:0] nn;
            nn = $signed({8'd0, lo_s[c*8 +: 8], 16'd0})
               + ($signed({1'b0, hi_s[c*8 +: 8]}) - $signed({1'b0, lo_s[c*8 +: 8]}))
                 * $signed({15'd0, frac});
            num[c] <= (nn < 0) ? '0 : nn[22:0];
          end
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          for (int c = 0; c < 3; c++) begin
            logic [31:0] s;
            s = {9'd0, num[c]} * 32'd255 + HALF;
            yv[c] <= s[31:16];
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_data  <= {3'd0, cur.row, cur.col, qv[2], qv[1], qv[0]};
            out_last  <= cur.last;
            out_full  <= cur.full;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < {1'b0, span}))
    else $error("division remainder not below span");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAP) |-> (t <= T_ONE))
    else $error("normalised level above one");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("pixel shown outside output step");

endmodule
